FILE: src/rsas_pkg.sv
// shared types and constants for the rotated sorted array search core
package rsas_pkg;

	localparam int ELEM_W     = 32;
	localparam int IN_TDATA_W = 64;
	localparam int IN_TUSER_W = 2;
	localparam int OUT_TDATA_W = 8;

	// input tuser bit positions
	localparam int TU_REQ_TYPE  = 0;
	localparam int TU_NEW_ARRAY = 1;

	// output tdata bit positions
	localparam int TD_FOUND      = 0;
	localparam int TD_OVERFLOWED = 1;

	// request kinds carried in tuser
	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MID  = 6'b000010,
		ST_LO   = 6'b000100,
		ST_HI   = 6'b001000,
		ST_CMP  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

endpackage

FILE: src/rsas_ram.sv
// generic simple dual-port ram with one write port and one registered read port
module rsas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/rotated_sorted_array_search_core.sv
// top level: element store and binary search over a rotated sorted array
//
// usage
// - s_axis carries requests. tuser[0] is the request kind (0 append, 1 search),
//   tuser[1] starts a new array on an append. tdata[31:0] is the element to
//   append, tdata[63:32] the search target, both signed.
// - an append beat gives no result; appends past DEPTH
//   elements are dropped and set the overflow flag until the next new array.
// - a search beat gives exactly one m_axis beat: tdata[0] found,
//   tdata[1] overflowed, tdata[7:2] zero.
// - search: the store is one ram with a single read port, so each search step
//   reads mid, lo and hi-1 in turn and then decides. steps is about log2(n)
//   for n elements, up to n when duplicates force the one-element shrink.
//   the next request is taken in the cycle after the result register loads.
//   s_axis_tready is low while a search runs.
// - the result sits in an output register; appends are still taken while it
//   waits. a finished search holds until m_axis_tready frees that register.
// - reset clears the element count, the overflow flag and all control state;
//   the store itself is not cleared, reads only touch entries below the count.
module rotated_sorted_array_search_core #(
	parameter int DEPTH = 1024
) (
	input  logic clk,
	input  logic arst_n,
	// requests
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [rsas_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // element_value, search_target
	input  logic [rsas_pkg::IN_TUSER_W-1:0]  s_axis_tuser,  // req_type, new_array
	// results
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [rsas_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // found, overflowed, zero pad
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	rsas_pkg::state_t state_q;

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [CW-1:0] lo_q, hi_q, mid_q;
	logic signed [rsas_pkg::ELEM_W-1:0] t_q, vm_q, vl_q;
	logic          found_q;
	logic          m_valid_q, m_found_q, m_ovf_q;

	// input beat decode
	logic in_beat, is_search, is_append;
	logic signed [rsas_pkg::ELEM_W-1:0] in_elem, in_target;

	assign s_axis_tready = (state_q == rsas_pkg::ST_IDLE);
	assign in_beat   = s_axis_tvalid && s_axis_tready;
	assign is_search = (s_axis_tuser[rsas_pkg::TU_REQ_TYPE] == rsas_pkg::REQ_SEARCH);
	assign is_append = (s_axis_tuser[rsas_pkg::TU_REQ_TYPE] == rsas_pkg::REQ_APPEND);
	assign in_elem   = s_axis_tdata[rsas_pkg::ELEM_W-1:0];
	assign in_target = s_axis_tdata[2*rsas_pkg::ELEM_W-1:rsas_pkg::ELEM_W];

	// append path: writes happen only in idle, reads only during a search,
	// so the fsm itself keeps ram writes and reads apart
	logic [CW-1:0] wr_idx;
	logic          wr_fits;
	logic          ram_we;

	assign wr_idx  = s_axis_tuser[rsas_pkg::TU_NEW_ARRAY] ? '0 : count_q;
	assign wr_fits = (wr_idx < DEPTH_C);
	assign ram_we  = in_beat && is_append && wr_fits;

	// search address generation
	logic [CW:0]   sum;
	logic [CW-1:0] mid_now;
	logic [CW-1:0] hi_dec;
	logic          range_open;
	logic          ram_re;
	logic [AW-1:0] raddr;
	logic [rsas_pkg::ELEM_W-1:0] rdata;

	assign sum        = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_now    = sum[CW:1];
	assign hi_dec     = hi_q - CW'(1);
	assign range_open = (lo_q < hi_q);

	always_comb begin
		ram_re = 1'b0;
		raddr  = mid_now[AW-1:0];
		case (state_q)
			rsas_pkg::ST_MID: begin
				ram_re = range_open;
				raddr  = mid_now[AW-1:0];
			end
			rsas_pkg::ST_LO: begin
				ram_re = 1'b1;
				raddr  = lo_q[AW-1:0];
			end
			rsas_pkg::ST_HI: begin
				ram_re = 1'b1;
				raddr  = hi_dec[AW-1:0];
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	rsas_ram #(
		.WIDTH(rsas_pkg::ELEM_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx[AW-1:0]),
		.wdata (in_elem),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// decision step: vm and vl were captured, vh arrives from the ram now
	logic signed [rsas_pkg::ELEM_W-1:0] vh;
	logic          hit;
	logic [CW-1:0] lo_nxt, hi_nxt;

	assign vh  = $signed(rdata);
	assign hit = (t_q == vm_q);

	always_comb begin
		lo_nxt = lo_q;
		hi_nxt = hi_q;
		if (vl_q < vm_q) begin
			// left half sorted
			if (vl_q <= t_q && t_q < vm_q) begin
				hi_nxt = mid_q;
			end else begin
				lo_nxt = mid_q + CW'(1);
			end
		end else if (vm_q < vh) begin
			// right half sorted
			if (vm_q < t_q && t_q <= vh) begin
				lo_nxt = mid_q + CW'(1);
			end else begin
				hi_nxt = mid_q;
			end
		end else if (vl_q == vm_q) begin
			// duplicates hide the sorted half: drop one from the low end
			lo_nxt = lo_q + CW'(1);
		end else begin
			hi_nxt = hi_dec;
		end
	end

	logic out_free;
	assign out_free = !m_valid_q || m_axis_tready;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rsas_pkg::ST_IDLE;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			case (state_q)
				rsas_pkg::ST_IDLE: begin
					if (in_beat && is_append) begin
						if (wr_fits) begin
							count_q <= wr_idx + CW'(1);
						end else begin
							count_q <= wr_idx;
						end
						if (s_axis_tuser[rsas_pkg::TU_NEW_ARRAY]) begin
							ovf_q <= !wr_fits;
						end else if (!wr_fits) begin
							ovf_q <= 1'b1;
						end
					end else if (in_beat && is_search) begin
						state_q <= rsas_pkg::ST_MID;
					end
				end
				rsas_pkg::ST_MID: begin
					state_q <= range_open ? rsas_pkg::ST_LO : rsas_pkg::ST_DONE;
				end
				rsas_pkg::ST_LO: begin
					state_q <= rsas_pkg::ST_HI;
				end
				rsas_pkg::ST_HI: begin
					state_q <= rsas_pkg::ST_CMP;
				end
				rsas_pkg::ST_CMP: begin
					state_q <= hit ? rsas_pkg::ST_DONE : rsas_pkg::ST_MID;
				end
				rsas_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= rsas_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= rsas_pkg::ST_IDLE;
				end
			endcase
			// result register: load on a finished search, clear once taken
			if (state_q == rsas_pkg::ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			rsas_pkg::ST_IDLE: begin
				lo_q    <= '0;
				hi_q    <= count_q;
				t_q     <= in_target;
				found_q <= 1'b0;
			end
			rsas_pkg::ST_MID: begin
				mid_q <= mid_now;
			end
			rsas_pkg::ST_LO: begin
				vm_q <= $signed(rdata);
			end
			rsas_pkg::ST_HI: begin
				vl_q <= $signed(rdata);
			end
			rsas_pkg::ST_CMP: begin
				found_q <= hit;
				lo_q    <= lo_nxt;
				hi_q    <= hi_nxt;
			end
			rsas_pkg::ST_DONE: begin
				if (out_free) begin
					m_found_q <= found_q;
					m_ovf_q   <= ovf_q;
				end
			end
			default: begin
				found_q <= found_q;
			end
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[rsas_pkg::TD_FOUND]      = m_found_q;
		m_axis_tdata[rsas_pkg::TD_OVERFLOWED] = m_ovf_q;
	end

endmodule

FILE: src/rsas_checker.sv
// port-level checker for the rotated sorted array search core, with its bind
module rsas_checker (
	input logic clk,
	input logic arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [rsas_pkg::IN_TUSER_W-1:0]  s_axis_tuser,   // req_type, new_array
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [rsas_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // found, overflowed, zero pad
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// pad bits above the two flags stay zero
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[rsas_pkg::OUT_TDATA_W-1:rsas_pkg::TD_OVERFLOWED+1] == '0)
		else $error("result pad bits not zero");

	// an append never produces a result beat
	a_append_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready &&
		s_axis_tuser[rsas_pkg::TU_REQ_TYPE] == rsas_pkg::REQ_APPEND && !m_axis_tvalid
		|=> !m_axis_tvalid)
		else $error("result beat after an append");

	// a search occupies the block: no request taken in the next cycle
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready &&
		s_axis_tuser[rsas_pkg::TU_REQ_TYPE] == rsas_pkg::REQ_SEARCH
		|=> !s_axis_tready)
		else $error("request taken right after a search beat");

endmodule

bind rotated_sorted_array_search_core rsas_checker u_rsas_checker (.*);

FILE: tb/rotated_sorted_array_search_core_test.sv
// testbench for the rotated sorted array search core: stream stimulus, predictor and checker
`timescale 1ns / 100ps

module rotated_sorted_array_search_core_test;

	localparam int DEPTH        = 1024;
	localparam int RANDOM_ITEMS = 1250;
	localparam int HOLD_CYCLES  = 2000;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 20000000;

	localparam logic signed [rsas_pkg::ELEM_W-1:0] ELEM_MIN = 32'sh80000000;
	localparam logic signed [rsas_pkg::ELEM_W-1:0] ELEM_MAX = 32'sh7fffffff;

	typedef struct packed {
		logic                               kind;
		logic                               fresh;
		logic signed [rsas_pkg::ELEM_W-1:0] elem;
		logic signed [rsas_pkg::ELEM_W-1:0] target;
	} request_t;

	typedef struct packed {
		logic found;
		logic overflowed;
	} answer_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [rsas_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // element_value, search_target
	logic [rsas_pkg::IN_TUSER_W-1:0]  s_axis_tuser  = '0;  // req_type, new_array
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [rsas_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // found, overflowed, zero pad

	rotated_sorted_array_search_core #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #2 clk = ~clk;

	// requests waiting for the driver, answers waiting for the monitor
	request_t pending_requests[$];
	answer_t  expected_answers[$];

	// predictor copy of the block state
	logic signed [rsas_pkg::ELEM_W-1:0] stored_elems [DEPTH];
	int unsigned                        stored_count = 0;
	logic                               store_overflow = 1'b0;

	// scratch array the stimulus generator builds sequences in
	logic signed [rsas_pkg::ELEM_W-1:0] seq_vals[$];

	int random_items    = 0;
	int arrays_built    = 0;
	int appends_taken   = 0;
	int searches_taken  = 0;
	int overflow_hits   = 0;
	int results_checked = 0;
	int mismatches      = 0;
	int holds_done      = 0;
	int hold_left       = 0;
	int cycle_count     = 0;

	// ---------------------------------------------------------------- predictor

	function automatic logic predict_found(input logic signed [rsas_pkg::ELEM_W-1:0] target);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		logic signed [rsas_pkg::ELEM_W-1:0] v_mid;
		logic signed [rsas_pkg::ELEM_W-1:0] v_lo;
		logic signed [rsas_pkg::ELEM_W-1:0] v_hi;
		lo = 0;
		hi = stored_count;
		while (lo < hi) begin
			mid   = (lo + hi) >> 1;
			v_mid = stored_elems[mid];
			v_lo  = stored_elems[lo];
			v_hi  = stored_elems[hi - 1];
			if (target == v_mid)
				return 1'b1;
			if (v_lo < v_mid) begin
				// left half ascending
				if (v_lo <= target && target < v_mid)
					hi = mid;
				else
					lo = mid + 1;
			end else if (v_mid < v_hi) begin
				// right half ascending
				if (v_mid < target && target <= v_hi)
					lo = mid + 1;
				else
					hi = mid;
			end else if (v_lo == v_mid) begin
				// duplicates hide the sorted half
				lo++;
			end else begin
				hi--;
			end
		end
		return 1'b0;
	endfunction

	// update the predictor with one accepted beat
	task automatic apply_request(input request_t req);
		answer_t ans;
		if (req.kind == rsas_pkg::REQ_APPEND) begin
			appends_taken++;
			if (req.fresh) begin
				stored_count   = 0;
				store_overflow = 1'b0;
			end
			if (stored_count < DEPTH) begin
				stored_elems[stored_count] = req.elem;
				stored_count++;
			end else begin
				store_overflow = 1'b1;
			end
		end else begin
			searches_taken++;
			ans.found      = predict_found(req.target);
			ans.overflowed = store_overflow;
			if (store_overflow)
				overflow_hits++;
			expected_answers.push_back(ans);
		end
	endtask

	// ---------------------------------------------------------------- stimulus

	task automatic push_append(input logic fresh,
	                           input logic signed [rsas_pkg::ELEM_W-1:0] value);
		request_t req;
		req.kind   = rsas_pkg::REQ_APPEND;
		req.fresh  = fresh;
		req.elem   = value;
		req.target = $urandom;  // unused on an append, toggled anyway
		pending_requests.push_back(req);
		random_items++;
	endtask

	task automatic push_search(input logic signed [rsas_pkg::ELEM_W-1:0] target);
		request_t req;
		req.kind   = rsas_pkg::REQ_SEARCH;
		req.fresh  = 1'($urandom_range(0, 1));  // ignored on a search
		req.elem   = $urandom;
		req.target = target;
		pending_requests.push_back(req);
		random_items++;
	endtask

	// ascending run with steps up to step_max, clamped at the top, then rotated
	task automatic build_sorted(input int n, input longint step_max);
		longint acc;
		int     rot;
		seq_vals.delete();
		case ($urandom_range(0, 7))
			0:       acc = ELEM_MIN;
			1:       acc = longint'(ELEM_MAX) - n;
			default: acc = longint'($signed($urandom));
		endcase
		for (int i = 0; i < n; i++) begin
			if (acc > longint'(ELEM_MAX))
				acc = ELEM_MAX;
			seq_vals.push_back(acc[rsas_pkg::ELEM_W-1:0]);
			acc += longint'($urandom) % (step_max + 1);
		end
		rot = $urandom_range(0, n - 1);
		repeat (rot) seq_vals.push_back(seq_vals.pop_front());
	endtask

	function automatic logic signed [rsas_pkg::ELEM_W-1:0] pick_target();
		logic signed [rsas_pkg::ELEM_W-1:0] v;
		v = seq_vals[$urandom_range(0, seq_vals.size() - 1)];
		case ($urandom_range(0, 6))
			0, 1, 2: return v;
			3:       return v + 1;
			4:       return v - 1;
			5:       return $urandom;
			default: return $urandom_range(0, 1) ? ELEM_MIN : ELEM_MAX;
		endcase
	endfunction

	task automatic queue_searches(input int k);
		repeat (k) push_search(pick_target());
	endtask

	// appends of seq_vals, now and then a stray search in the middle
	task automatic load_sequence(input logic fresh_first, input int first, input int last);
		for (int i = first; i < last; i++) begin
			push_append(i == first && fresh_first, seq_vals[i]);
			if ($urandom_range(0, 19) == 0)
				push_search(pick_target());
		end
	endtask

	// fill the store to capacity, search, then push past it and search again
	task automatic fill_past_capacity(input longint step_max);
		int extra;
		extra = $urandom_range(1, 8);
		build_sorted(DEPTH + extra, step_max);
		for (int i = 0; i < DEPTH; i++)
			push_append(i == 0, seq_vals[i]);
		queue_searches(2);
		for (int i = DEPTH; i < DEPTH + extra; i++)
			push_append(1'b0, seq_vals[i]);
		push_search(seq_vals[DEPTH]);  // a dropped element
		queue_searches(3);
		arrays_built++;
	endtask

	// ---------------------------------------------------------------- driver

	function automatic logic driver_quiet();
		return (appends_taken + searches_taken) inside {[300:700]};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				apply_request(pending_requests.pop_front());
			if (s_axis_tvalid && !s_axis_tready) begin
				// beat still waiting, hold it
			end else if (pending_requests.size() != 0
			             && (driver_quiet() || $urandom_range(0, 99) >= 10)) begin
				s_axis_tvalid                        <= 1'b1;
				s_axis_tdata                         <= {pending_requests[0].target,
				                                         pending_requests[0].elem};
				s_axis_tuser[rsas_pkg::TU_REQ_TYPE]  <= pending_requests[0].kind;
				s_axis_tuser[rsas_pkg::TU_NEW_ARRAY] <= pending_requests[0].fresh;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic report_mismatch(input string field, input logic [7:0] exp_v,
	                               input logic [7:0] act_v);
		$display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, exp_v, act_v);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t ans;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left     <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_answers.size() == 0) begin
					$display("%0t ns: result beat with none expected, expected none actual %0h",
					         $time, m_axis_tdata);
					mismatches++;
				end else begin
					ans = expected_answers.pop_front();
					if (m_axis_tdata[rsas_pkg::TD_FOUND] !== ans.found)
						report_mismatch("found", 8'(ans.found),
						                8'(m_axis_tdata[rsas_pkg::TD_FOUND]));
					if (m_axis_tdata[rsas_pkg::TD_OVERFLOWED] !== ans.overflowed)
						report_mismatch("overflowed", 8'(ans.overflowed),
						                8'(m_axis_tdata[rsas_pkg::TD_OVERFLOWED]));
					if (m_axis_tdata[rsas_pkg::OUT_TDATA_W-1:2] !== '0)
						report_mismatch("pad", 8'h00,
						                8'(m_axis_tdata[rsas_pkg::OUT_TDATA_W-1:2]));
				end
				results_checked++;
			end
			// long hold-offs back the core up while appends keep coming
			if (hold_left > 0) begin
				hold_left     <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if ((holds_done == 0 && results_checked >= 10)
			             || (holds_done == 1 && results_checked >= 35)) begin
				holds_done    <= holds_done + 1;
				hold_left     <= HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= (results_checked inside {[15:30]})
				                 || $urandom_range(0, 99) >= 10;
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d requests and %0d results outstanding",
			         cycle_count, pending_requests.size(), expected_answers.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int n;
		int mode;
		int round;
		longint step_max;
		logic fresh;

		// empty array right after reset
		push_search(32'sd0);

		// rotated extremes: max, min, 0 stored as 0, max, min
		push_append(1'b1, 32'sd0);
		push_append(1'b0, ELEM_MAX);
		push_append(1'b0, ELEM_MIN);
		push_search(ELEM_MIN);
		push_search(ELEM_MAX);
		push_search(32'sd0);
		push_search(-32'sd1);
		push_search(32'sd1);

		// single element
		push_append(1'b1, 32'sd5);
		push_search(32'sd5);
		push_search(32'sd4);

		// duplicates hiding the sorted half
		push_append(1'b1, 32'sd2);
		push_append(1'b0, 32'sd2);
		push_append(1'b0, 32'sd2);
		push_append(1'b0, 32'sd1);
		push_append(1'b0, 32'sd2);
		push_search(32'sd1);
		push_search(32'sd3);
		push_search(ELEM_MIN);
		push_search(ELEM_MAX);

		random_items = 0;
		round = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (round == 8) begin
				fill_past_capacity(1);
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
				mode = $urandom_range(0, 9);
				case (mode)
					0:          step_max = 0;  // all equal: one element a step
					1, 2, 3:    step_max = 1;
					4, 5, 6:    step_max = 3;
					default:    step_max = 64'd1 << 20;
				endcase
				if (mode == 9) begin
					// unsorted noise
					seq_vals.delete();
					repeat (n) seq_vals.push_back($urandom);
				end else begin
					build_sorted(n, step_max);
				end
				// now and then keep appending onto the previous array
				fresh = ($urandom_range(0, 9) != 0);
				load_sequence(fresh, 0, n);
				queue_searches($urandom_range(1, 6));
				arrays_built++;
			end
			round++;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || expected_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d appends and %0d searches over %0d arrays, %0d answers overflowed",
		         appends_taken, searches_taken, arrays_built, overflow_hits);
		$display("checked %0d result beats, %0d receiver hold-offs, %0d mismatches",
		         results_checked, holds_done, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
src/rsas_pkg.sv
src/rsas_ram.sv
src/rotated_sorted_array_search_core.sv
src/rsas_checker.sv
tb/rotated_sorted_array_search_core_test.sv
